FILE: rtl/m2m_pkg.sv
// m2m_pkg: shared types and constants for the mask-to-mask collision unit.
// No dependencies; m2m_in_if, m2m_row_cmp and the collision unit import it.
package m2m_pkg;

	// default geometry of the stored masks
	localparam int MASK_WIDTH_DEF  = 64;
	localparam int MASK_HEIGHT_DEF = 64;

	// fixed field widths
	localparam int ROW_W      = 64; // row word carried by an input beat
	localparam int ROW_IDX_W  = 6;  // row index field
	localparam int COORD_W    = 13; // signed screen position
	localparam int DIM_W      = 7;  // mask width / height
	localparam int EXT_W      = 15; // position plus dimension, signed, no overflow
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13; // widest register

	// input beat action codes (code 3 is unused and ignored)
	typedef enum logic [1:0] {
		ACT_LOAD_A = 2'd0,
		ACT_LOAD_B = 2'd1,
		ACT_TEST   = 2'd2
	} m2m_action_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_A_X      = 3'd0,
		CFG_A_Y      = 3'd1,
		CFG_A_WIDTH  = 3'd2,
		CFG_A_HEIGHT = 3'd3,
		CFG_B_X      = 3'd4,
		CFG_B_Y      = 3'd5,
		CFG_B_WIDTH  = 3'd6,
		CFG_B_HEIGHT = 3'd7
	} m2m_cfg_t;

	// test sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GEOM,
		ST_CLIP,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} m2m_state_t;

endpackage

FILE: rtl/m2m_in_if.sv
// m2m_in_if: input channel (load / test beats) with valid/ready handshake.
// Depends on m2m_pkg for field widths.
interface m2m_in_if;
	import m2m_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [1:0]           action;
	logic [ROW_IDX_W-1:0] row_index;
	logic [ROW_W-1:0]     row_bits;

	modport source (output valid, output action, output row_index, output row_bits,
		input ready);
	modport sink (input valid, input action, input row_index, input row_bits,
		output ready);
endinterface

FILE: rtl/m2m_out_if.sv
// m2m_out_if: result channel (hit, boxes_overlap) with valid/ready handshake.
// No dependencies.
interface m2m_out_if;
	logic valid;
	logic ready;
	logic hit;
	logic boxes_overlap;

	modport source (output valid, output hit, output boxes_overlap, input ready);
	modport sink (input valid, input hit, input boxes_overlap, output ready);
endinterface

FILE: rtl/mask_to_mask_collision_unit.sv
// mask_to_mask_collision_unit: pixel-exact collision test of two bit masks.
// A load leaves the block in IDLE, so it stays ready for the next beat.
// A test steps GEOM, CLIP, then DONE when the boxes miss, else SCAN over the H overlap rows
// (H = overlap height, at most 64 by default), stopping after the first hit, then DRAIN, DONE.
// Ready stays low for the whole test, longer while the previous result beat waits; one RAM row
// pair per cycle through the shared row compare. arst_n clears control and config only.
module mask_to_mask_collision_unit import m2m_pkg::*; #(
	parameter int MASK_WIDTH  = MASK_WIDTH_DEF,
	parameter int MASK_HEIGHT = MASK_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	m2m_in_if.sink                in_ch,
	m2m_out_if.source             out_ch
);
	localparam int AW   = (MASK_HEIGHT > 1) ? $clog2(MASK_HEIGHT) : 1;
	localparam int SH_W = $clog2(MASK_WIDTH);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [COORD_W-1:0] a_x_q, a_y_q, b_x_q, b_y_q;
	logic [DIM_W-1:0]          a_w_q, a_h_q, b_w_q, b_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_x_q <= '0;
			a_y_q <= '0;
			a_w_q <= '0;
			a_h_q <= '0;
			b_x_q <= '0;
			b_y_q <= '0;
			b_w_q <= '0;
			b_h_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (m2m_cfg_t'(cfg_index))
				CFG_A_X:      a_x_q <= cfg_data;
				CFG_A_Y:      a_y_q <= cfg_data;
				CFG_A_WIDTH:  a_w_q <= cfg_data[DIM_W-1:0];
				CFG_A_HEIGHT: a_h_q <= cfg_data[DIM_W-1:0];
				CFG_B_X:      b_x_q <= cfg_data;
				CFG_B_Y:      b_y_q <= cfg_data;
				CFG_B_WIDTH:  b_w_q <= cfg_data[DIM_W-1:0];
				CFG_B_HEIGHT: b_h_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Dimensions clamp to the stored mask size; positions widen to EXT_W so
	// position + dimension never wraps.
	logic [DIM_W-1:0]        a_w_c, a_h_c, b_w_c, b_h_c;
	logic signed [EXT_W-1:0] ax, ay, bx, by;
	logic signed [EXT_W-1:0] aw, ah, bw, bh;

	assign a_w_c = (32'(a_w_q) > MASK_WIDTH)  ? DIM_W'(MASK_WIDTH)  : a_w_q;
	assign b_w_c = (32'(b_w_q) > MASK_WIDTH)  ? DIM_W'(MASK_WIDTH)  : b_w_q;
	assign a_h_c = (32'(a_h_q) > MASK_HEIGHT) ? DIM_W'(MASK_HEIGHT) : a_h_q;
	assign b_h_c = (32'(b_h_q) > MASK_HEIGHT) ? DIM_W'(MASK_HEIGHT) : b_h_q;

	assign ax = EXT_W'(a_x_q);
	assign ay = EXT_W'(a_y_q);
	assign bx = EXT_W'(b_x_q);
	assign by = EXT_W'(b_y_q);
	assign aw = EXT_W'(a_w_c);
	assign ah = EXT_W'(a_h_c);
	assign bw = EXT_W'(b_w_c);
	assign bh = EXT_W'(b_h_c);

	// ------------------------------------------------------------------
	// Input beat decode and mask RAM writes
	// ------------------------------------------------------------------
	m2m_state_t state_q, state_d;

	logic          in_fire;
	logic          row_ok;
	logic [31:0]   row_ext;
	logic [AW-1:0] wr_addr;
	logic          we_a, we_b;
	logic          test_go;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;

	// loads past the stored height are dropped
	assign row_ext = 32'(in_ch.row_index);
	assign row_ok  = (row_ext < MASK_HEIGHT);
	assign wr_addr = row_ext[AW-1:0];

	assign we_a    = in_fire && (in_ch.action == ACT_LOAD_A) && row_ok;
	assign we_b    = in_fire && (in_ch.action == ACT_LOAD_B) && row_ok;
	assign test_go = in_fire && (in_ch.action == ACT_TEST);

	logic [AW-1:0]         ra_q, rb_q;
	logic [MASK_WIDTH-1:0] rd_a, rd_b;

	m2m_ram #(.WIDTH(MASK_WIDTH), .DEPTH(MASK_HEIGHT), .AW(AW)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (wr_addr),
		.wdata (in_ch.row_bits[MASK_WIDTH-1:0]),
		.raddr (ra_q),
		.rdata (rd_a)
	);

	m2m_ram #(.WIDTH(MASK_WIDTH), .DEPTH(MASK_HEIGHT), .AW(AW)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (wr_addr),
		.wdata (in_ch.row_bits[MASK_WIDTH-1:0]),
		.raddr (rb_q),
		.rdata (rd_b)
	);

	// ------------------------------------------------------------------
	// Test datapath
	// GEOM: overlap rectangle corners. CLIP: overlap flag, window size,
	// column shifts, first rows. SCAN: one row pair per cycle.
	// ------------------------------------------------------------------
	logic signed [EXT_W-1:0] ox_q, ex_q, oy_q, ey_q;
	logic signed [EXT_W-1:0] a_ex, b_ex, a_ey, b_ey;
	logic signed [EXT_W-1:0] ow_f, oh_f, sa_f, sb_f, ra_f, rb_f;

	logic                  overlap_q;
	logic [DIM_W-1:0]      ow_q;
	logic [DIM_W-1:0]      rows_left_q;
	logic [SH_W-1:0]       sa_q, sb_q;
	logic                  hit_q;
	logic                  rd_vld_s1;
	logic                  row_any;

	logic                  issue;
	logic                  out_load;
	logic                  out_valid_q;
	logic                  out_hit_q;
	logic                  out_ovl_q;

	assign a_ex = ax + aw;
	assign b_ex = bx + bw;
	assign a_ey = ay + ah;
	assign b_ey = by + bh;

	assign ow_f = ex_q - ox_q;
	assign oh_f = ey_q - oy_q;
	// shifts and start rows are nonnegative and in range whenever boxes overlap
	assign sa_f = ox_q - ax;
	assign sb_f = ox_q - bx;
	assign ra_f = oy_q - ay;
	assign rb_f = oy_q - by;

	m2m_row_cmp #(.MASK_WIDTH(MASK_WIDTH), .SH_W(SH_W)) u_row_cmp (
		.row_a   (rd_a),
		.row_b   (rd_b),
		.shift_a (sa_q),
		.shift_b (sb_q),
		.span    (ow_q),
		.any     (row_any)
	);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		issue    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (test_go) begin
					state_d = ST_GEOM;
				end
			end
			ST_GEOM: state_d = ST_CLIP;
			ST_CLIP: begin
				if ((ox_q < ex_q) && (oy_q < ey_q)) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				// stop once rows are exhausted or a hit has landed
				if ((rows_left_q == '0) || hit_q) begin
					state_d = ST_DRAIN;
				end else begin
					issue = 1'b1;
				end
			end
			// spare state; the last compare already landed on the way out of SCAN
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (test_go) begin
				hit_q <= 1'b0;
			end else if (rd_vld_s1 && row_any) begin
				hit_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_GEOM) begin
			ox_q <= (ax > bx) ? ax : bx;
			oy_q <= (ay > by) ? ay : by;
			ex_q <= (a_ex < b_ex) ? a_ex : b_ex;
			ey_q <= (a_ey < b_ey) ? a_ey : b_ey;
		end
		if (state_q == ST_CLIP) begin
			overlap_q   <= (ox_q < ex_q) && (oy_q < ey_q);
			ow_q        <= ow_f[DIM_W-1:0];
			rows_left_q <= oh_f[DIM_W-1:0];
			sa_q        <= sa_f[SH_W-1:0];
			sb_q        <= sb_f[SH_W-1:0];
			ra_q        <= ra_f[AW-1:0];
			rb_q        <= rb_f[AW-1:0];
		end else if (issue) begin
			rows_left_q <= rows_left_q - DIM_W'(1);
			ra_q        <= ra_q + AW'(1);
			rb_q        <= rb_q + AW'(1);
		end
		if (out_load) begin
			out_hit_q <= hit_q;
			out_ovl_q <= overlap_q;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.hit           = out_hit_q;
	assign out_ch.boxes_overlap = out_ovl_q;
endmodule

FILE: rtl/m2m_ram.sv
// m2m_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module m2m_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/m2m_row_cmp.sv
// m2m_row_cmp: row compare unit; aligns one row of each mask to the overlap
// window and flags any common set pixel. Depends on m2m_pkg.
module m2m_row_cmp import m2m_pkg::*; #(
	parameter int MASK_WIDTH = MASK_WIDTH_DEF,
	parameter int SH_W       = $clog2(MASK_WIDTH)
) (
	input  logic [MASK_WIDTH-1:0] row_a,
	input  logic [MASK_WIDTH-1:0] row_b,
	input  logic [SH_W-1:0]       shift_a,
	input  logic [SH_W-1:0]       shift_b,
	input  logic [DIM_W-1:0]      span,
	output logic                  any
);
	logic [MASK_WIDTH-1:0] col_mask;
	logic [MASK_WIDTH-1:0] al_a;
	logic [MASK_WIDTH-1:0] al_b;

	// column j of the window is live when j < span
	always_comb begin
		for (int j = 0; j < MASK_WIDTH; j++) begin
			col_mask[j] = (32'(j) < 32'(span));
		end
	end

	assign al_a = row_a >> shift_a;
	assign al_b = row_b >> shift_b;
	assign any  = |(al_a & al_b & col_mask);
endmodule

FILE: dv/mask_to_mask_collision_unit_test.sv
// mask_to_mask_collision_unit_test: self-checking bench for the mask collision unit.
// Needs rtl/m2m_pkg.sv, rtl/m2m_in_if.sv, rtl/m2m_out_if.sv and the unit itself.
`timescale 1ns / 1ps

module mask_to_mask_collision_unit_test import m2m_pkg::*; ();

	// code 3 has no enum member: the unit drops such beats
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int MASK_COLS   = MASK_WIDTH_DEF;
	localparam int MASK_ROWS   = MASK_HEIGHT_DEF;
	localparam int STALL_LIMIT = 2000; // cycles with no beat on either side
	localparam int SETTLE_CYC  = 8;    // loads/dropped beats finish well inside this
	localparam int TAIL_CYC    = 80;   // one full-height scan plus margin

	typedef struct {
		logic [1:0]           action;
		logic [ROW_IDX_W-1:0] row_index;
		logic [ROW_W-1:0]     row_bits;
	} beat_t;

	typedef struct packed {
		logic hit;
		logic boxes_overlap;
	} verdict_t;

	typedef struct {
		logic signed [COORD_W-1:0] ax, ay, bx, by;
		logic [DIM_W-1:0]          aw, ah, bw, bh;
	} geometry_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	m2m_in_if  beat_if ();
	m2m_out_if verdict_if ();

	mask_to_mask_collision_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (beat_if),
		.out_ch    (verdict_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow state: geometry as programmed, mask images as loaded.
	// The stimulus side keeps its own "loaded" flags so a test never scans
	// a row that was never written (RAM is not cleared by reset).
	// ------------------------------------------------------------------
	geometry_t        geo;
	logic [ROW_W-1:0] a_image [MASK_ROWS];
	logic [ROW_W-1:0] b_image [MASK_ROWS];
	bit               a_loaded [MASK_ROWS];
	bit               b_loaded [MASK_ROWS];

	beat_t    pending_beats [$];
	verdict_t expected_verdicts [$];

	int mismatches   = 0;
	int quiet_cycles = 0;
	int idle_odds    = 0; // 0: no idling; else one chance in idle_odds per slot
	int send_gap     = 0;
	int sink_stall   = 0;
	beat_t    next_beat;
	verdict_t want;

	// Bounding box intersection. Dimensions above the mask size clamp to it.
	// Offsets give the first overlapped column/row inside each mask.
	function automatic logic box_overlap(input geometry_t g, output int a_col, b_col,
		a_row, b_row, span_w, span_h);
		int ax, ay, bx, by, aw, ah, bw, bh, ox, oy, ex, ey;
		ax = g.ax;
		ay = g.ay;
		bx = g.bx;
		by = g.by;
		aw = (g.aw > DIM_W'(MASK_COLS)) ? MASK_COLS : int'(g.aw);
		ah = (g.ah > DIM_W'(MASK_ROWS)) ? MASK_ROWS : int'(g.ah);
		bw = (g.bw > DIM_W'(MASK_COLS)) ? MASK_COLS : int'(g.bw);
		bh = (g.bh > DIM_W'(MASK_ROWS)) ? MASK_ROWS : int'(g.bh);
		ox = (ax > bx) ? ax : bx;
		oy = (ay > by) ? ay : by;
		ex = (ax + aw < bx + bw) ? ax + aw : bx + bw;
		ey = (ay + ah < by + bh) ? ay + ah : by + bh;
		a_col  = ox - ax;
		b_col  = ox - bx;
		a_row  = oy - ay;
		b_row  = oy - by;
		span_w = ex - ox;
		span_h = ey - oy;
		return (span_w > 0) && (span_h > 0);
	endfunction

	// Apply one accepted beat to the shadow state; returns 1 when it yields a verdict.
	function automatic logic predict_collision(input beat_t b, output verdict_t v);
		int a_col, b_col, a_row, b_row, span_w, span_h;
		logic [ROW_W-1:0] col_mask, wa, wb;
		logic produces;
		v = '0;
		produces = 1'b0;
		case (b.action)
			ACT_LOAD_A: a_image[b.row_index] = b.row_bits;
			ACT_LOAD_B: b_image[b.row_index] = b.row_bits;
			ACT_TEST: begin
				produces = 1'b1;
				v.boxes_overlap = box_overlap(geo, a_col, b_col, a_row, b_row, span_w, span_h);
				if (v.boxes_overlap) begin
					col_mask = (span_w >= ROW_W) ? '1 : ((64'd1 << span_w) - 64'd1);
					for (int r = 0; r < span_h && !v.hit; r++) begin
						wa = a_image[a_row + r] >> a_col;
						wb = b_image[b_row + r] >> b_col;
						if ((wa & wb & col_mask) != '0)
							v.hit = 1'b1;
					end
				end
			end
			default: ;
		endcase
		return produces;
	endfunction

	// ------------------------------------------------------------------
	// Driver: pops the next beat whenever the slot is free, with random gaps.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			beat_if.valid <= 1'b0;
			send_gap = 0;
		end else if (!beat_if.valid || beat_if.ready) begin
			if (send_gap == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
				send_gap = $urandom_range(1, 6);
			if (send_gap > 0) begin
				send_gap--;
				beat_if.valid <= 1'b0;
			end else if (pending_beats.size() != 0) begin
				next_beat = pending_beats.pop_front();
				beat_if.valid     <= 1'b1;
				beat_if.action    <= next_beat.action;
				beat_if.row_index <= next_beat.row_index;
				beat_if.row_bits  <= next_beat.row_bits;
			end else begin
				beat_if.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predicts on every accepted input beat, checks every result
	// beat against the oldest expectation, and throttles ready in bursts.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			verdict_if.ready <= 1'b0;
			sink_stall = 0;
		end else begin
			if (beat_if.valid && beat_if.ready) begin
				if (predict_collision('{beat_if.action, beat_if.row_index, beat_if.row_bits},
					want))
					expected_verdicts.push_back(want);
			end
			if (verdict_if.valid && verdict_if.ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("result beat with no verdict pending");
					mismatches++;
				end else begin
					want = expected_verdicts.pop_front();
					if (verdict_if.hit !== want.hit) begin
						$error("hit: expected %0b, actual %0b", want.hit, verdict_if.hit);
						mismatches++;
					end
					if (verdict_if.boxes_overlap !== want.boxes_overlap) begin
						$error("boxes_overlap: expected %0b, actual %0b",
							want.boxes_overlap, verdict_if.boxes_overlap);
						mismatches++;
					end
				end
			end
			if (sink_stall == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
				sink_stall = $urandom_range(1, 6);
			if (sink_stall > 0) begin
				sink_stall--;
				verdict_if.ready <= 1'b0;
			end else begin
				verdict_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without a beat on either channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (beat_if.valid && beat_if.ready)
			|| (verdict_if.valid && verdict_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("mask_to_mask_collision_unit: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_beat(input logic [1:0] act, input logic [ROW_IDX_W-1:0] row,
		input logic [ROW_W-1:0] bits);
		pending_beats.push_back('{act, row, bits});
		if (act == ACT_LOAD_A)
			a_loaded[row] = 1'b1;
		if (act == ACT_LOAD_B)
			b_loaded[row] = 1'b1;
	endtask

	// Mostly sparse rows so that misses are as common as hits.
	function automatic logic [ROW_W-1:0] row_pattern();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return 64'd1 << $urandom_range(0, 63);
			4: return {$urandom, $urandom};
			default: return {$urandom, $urandom} & {$urandom, $urandom}
				& {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
		endcase
	endfunction

	// Queue a test, first loading any row it will scan that holds nothing yet.
	task automatic push_test();
		int a_col, b_col, a_row, b_row, span_w, span_h;
		if (box_overlap(geo, a_col, b_col, a_row, b_row, span_w, span_h)) begin
			for (int r = 0; r < span_h; r++) begin
				if (!a_loaded[a_row + r])
					push_beat(ACT_LOAD_A, ROW_IDX_W'(a_row + r), row_pattern());
				if (!b_loaded[b_row + r])
					push_beat(ACT_LOAD_B, ROW_IDX_W'(b_row + r), row_pattern());
			end
		end
		// row_index/row_bits are don't-care on a test; keep them random
		push_beat(ACT_TEST, ROW_IDX_W'($urandom), {$urandom, $urandom});
	endtask

	// Block until both queues drain and the last beat has had time to land.
	// Checked on the falling edge so every beat of the last rising edge is seen.
	task automatic settle();
		do
			@(negedge clk);
		while (pending_beats.size() != 0 || beat_if.valid || expected_verdicts.size() != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input m2m_cfg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			CFG_A_X:      geo.ax = data;
			CFG_A_Y:      geo.ay = data;
			CFG_A_WIDTH:  geo.aw = data[DIM_W-1:0];
			CFG_A_HEIGHT: geo.ah = data[DIM_W-1:0];
			CFG_B_X:      geo.bx = data;
			CFG_B_Y:      geo.by = data;
			CFG_B_WIDTH:  geo.bw = data[DIM_W-1:0];
			CFG_B_HEIGHT: geo.bh = data[DIM_W-1:0];
			default: ;
		endcase
	endtask

	// Reprogram the whole geometry once the unit is idle. Dimension registers
	// are 7 bits, so junk in the upper data bits must be dropped.
	task automatic set_geometry(input int ax, ay, aw, ah, bx, by, bw, bh);
		logic [CFG_DATA_W-DIM_W-1:0] junk;
		junk = ($urandom_range(0, 3) == 0) ? (CFG_DATA_W-DIM_W)'($urandom) : '0;
		settle();
		write_reg(CFG_A_X,      COORD_W'(ax));
		write_reg(CFG_A_Y,      COORD_W'(ay));
		write_reg(CFG_A_WIDTH,  {junk, DIM_W'(aw)});
		write_reg(CFG_A_HEIGHT, {junk, DIM_W'(ah)});
		write_reg(CFG_B_X,      COORD_W'(bx));
		write_reg(CFG_B_Y,      COORD_W'(by));
		write_reg(CFG_B_WIDTH,  {junk, DIM_W'(bw)});
		write_reg(CFG_B_HEIGHT, {junk, DIM_W'(bh)});
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Sizes: zero, full, oversized (clamps) and everything in between.
	function automatic int pick_dim();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 64;
			2: return $urandom_range(65, 127);
			3: return 1;
			default: return $urandom_range(1, 64);
		endcase
	endfunction

	task automatic random_geometry();
		int ax, ay, bx, by, mode;
		mode = $urandom_range(0, 9);
		if (mode < 7) begin
			// close together: most tests see a real overlap
			ax = $urandom_range(0, 80) - 40;
			ay = $urandom_range(0, 80) - 40;
			bx = ax + $urandom_range(0, 140) - 70;
			by = ay + $urandom_range(0, 140) - 70;
		end else if (mode == 7) begin
			// top of the coordinate range: far edges pass 4095
			ax = 4095 - $urandom_range(0, 70);
			ay = 4095 - $urandom_range(0, 70);
			bx = 4095 - $urandom_range(0, 70);
			by = 4095 - $urandom_range(0, 70);
		end else if (mode == 8) begin
			ax = -4096 + $urandom_range(0, 70);
			ay = -4096 + $urandom_range(0, 70);
			bx = -4096 + $urandom_range(0, 70);
			by = -4096 + $urandom_range(0, 70);
		end else begin
			ax = $urandom_range(0, 8191) - 4096;
			ay = $urandom_range(0, 8191) - 4096;
			bx = $urandom_range(0, 8191) - 4096;
			by = $urandom_range(0, 8191) - 4096;
		end
		set_geometry(ax, ay, pick_dim(), pick_dim(), bx, by, pick_dim(), pick_dim());
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int pick;
		arst_n               = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		beat_if.valid        = 1'b0;
		beat_if.action       = '0;
		beat_if.row_index    = '0;
		beat_if.row_bits     = '0;
		verdict_if.ready     = 1'b0;
		geo = '{ax: '0, ay: '0, bx: '0, by: '0, aw: '0, ah: '0, bw: '0, bh: '0};
		foreach (a_image[i]) begin
			a_image[i]  = '0;
			b_image[i]  = '0;
			a_loaded[i] = 1'b0;
			b_loaded[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed ---
		idle_odds = 5;
		// registers still at reset: zero-size boxes, no overlap
		push_test();
		// unused action code is dropped without a verdict
		push_beat(ACT_UNUSED, 6'd63, '1);

		// A shifted up so its last two rows meet B's first two; full width
		set_geometry(0, -62, 64, 64, 0, 0, 64, 2);
		push_beat(ACT_LOAD_A, 6'd62, '1);
		push_beat(ACT_LOAD_A, 6'd63, 64'h8000_0000_0000_0000);
		push_beat(ACT_LOAD_B, 6'd0, '0);
		push_beat(ACT_LOAD_B, 6'd1, 64'h8000_0000_0000_0000);
		push_test();  // hit on column 63 of the last row
		push_beat(ACT_LOAD_B, 6'd1, 64'h7FFF_FFFF_FFFF_FFFF);
		push_test();  // boxes overlap, no shared pixel

		// A is 3 columns wide; its set bits above column 2 must not count
		set_geometry(0, 0, 3, 1, 0, 0, 64, 1);
		push_beat(ACT_LOAD_A, 6'd0, 64'hFFFF_FFFF_FFFF_FFF8);
		push_beat(ACT_LOAD_B, 6'd0, '1);
		push_test();

		// opposite corners of the coordinate space
		set_geometry(-4096, -4096, 64, 64, 4095, 4095, 64, 64);
		push_test();

		// oversized A clamps to 64x64; B is the single pixel at its far corner
		set_geometry(0, 0, 127, 127, 63, 63, 1, 1);
		push_test();

		// boxes only touch along an edge: no area
		set_geometry(0, 0, 4, 4, 4, 0, 4, 4);
		push_test();

		// --- random phases ---
		// each geometry change drains the unit first, so the sender sits
		// idle until every verdict is back; last two phases run flat out
		for (int phase = 0; phase < 13; phase++) begin
			random_geometry();
			case ($urandom_range(0, 3))
				0: idle_odds = 0;
				1: idle_odds = 3;
				2: idle_odds = 6;
				default: idle_odds = 12;
			endcase
			if (phase >= 11)
				idle_odds = 0;
			repeat (44) begin
				pick = $urandom_range(0, 99);
				if (pick < 35)
					push_beat(ACT_LOAD_A, ROW_IDX_W'($urandom_range(0, 63)), row_pattern());
				else if (pick < 70)
					push_beat(ACT_LOAD_B, ROW_IDX_W'($urandom_range(0, 63)), row_pattern());
				else if (pick < 95)
					push_test();
				else
					push_beat(ACT_UNUSED, ROW_IDX_W'($urandom), {$urandom, $urandom});
			end
		end

		settle();
		repeat (TAIL_CYC) @(posedge clk);
		if (mismatches == 0)
			$display("mask_to_mask_collision_unit: match");
		else
			$display("mask_to_mask_collision_unit: mismatch");
		$finish;
	end

endmodule

FILE: mask_to_mask_collision_unit.f
rtl/m2m_pkg.sv
rtl/m2m_in_if.sv
rtl/m2m_out_if.sv
rtl/m2m_ram.sv
rtl/m2m_row_cmp.sv
rtl/mask_to_mask_collision_unit.sv
dv/mask_to_mask_collision_unit_test.sv
